[rtl/geohash_encoder_assert.svh]
// ----------------------------------------------------------------------------
// geohash encoder assertion macros
// concurrent assertion wrappers, compiled out for synthesis
// ----------------------------------------------------------------------------
`ifndef GEOHASH_ENCODER_ASSERT_SVH
`define GEOHASH_ENCODER_ASSERT_SVH

`ifndef SYNTHESIS
// checked only out of reset
`define GHE_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
// checked at every edge, reset included
`define GHE_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define GHE_ASSERT(label, prop, msg)
`define GHE_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

[rtl/ghe_pkg.sv]
// ----------------------------------------------------------------------------
// geohash encoder package
// token type, fixed point limits, alphabet and register codes
// ----------------------------------------------------------------------------
package ghe_pkg;

    localparam int CELLS = 5;

    // register indexes
    localparam logic [1:0] CFG_CHAR_BITS = 2'd0;
    localparam logic [1:0] CFG_PRECISION = 2'd1;

    localparam logic [2:0] BITS_HEX      = 3'd4;
    localparam logic [4:0] MAX_CHARS     = 5'd16;
    localparam logic [4:0] B32_MAX_CHARS = 5'd12;

    // degrees with 24 fractional bits
    localparam logic signed [32:0] LAT_LIM = 33'sd1509949440;
    localparam logic signed [33:0] LON_LIM = 34'sd3019898880;

    // half of each axis span in residual units
    localparam logic [31:0] LAT_HALF = 32'd1509949440;
    localparam logic [32:0] LON_HALF = 33'd3019898880;

    // one bisection token: residuals are offsets from the interval's low edge,
    // doubled after every step so the compare constant stays fixed
    typedef struct packed {
        logic        valid;
        logic        on_lon;
        logic [4:0]  grp;
        logic [31:0] lat_res;
        logic [32:0] lon_res;
    } t_tok;

    // "0123456789bcdefghjkmnpqrstuvwxyz", the 16 symbol set is its first half
    localparam logic [6:0] ALPHA32 [32] = '{
        7'd48,  7'd49,  7'd50,  7'd51,  7'd52,  7'd53,  7'd54,  7'd55,
        7'd56,  7'd57,  7'd98,  7'd99,  7'd100, 7'd101, 7'd102, 7'd103,
        7'd104, 7'd106, 7'd107, 7'd109, 7'd110, 7'd112, 7'd113, 7'd114,
        7'd115, 7'd116, 7'd117, 7'd118, 7'd119, 7'd120, 7'd121, 7'd122
    };

endpackage

[rtl/ghe_coord_if.sv]
// ----------------------------------------------------------------------------
// geohash coordinate channel
// valid/ready channel carrying one latitude/longitude pair per beat
// ----------------------------------------------------------------------------
interface ghe_coord_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] latitude;
    logic signed [32:0] longitude;

    modport source (output valid, latitude, longitude, input ready);
    modport sink   (input valid, latitude, longitude, output ready);
endinterface

[rtl/ghe_char_if.sv]
// ----------------------------------------------------------------------------
// geohash character channel
// valid/ready channel carrying one geohash character per beat
// ----------------------------------------------------------------------------
interface ghe_char_if;
    logic       valid;
    logic       ready;
    logic [6:0] char_code;
    logic [4:0] symbol;
    logic       last;

    modport source (output valid, char_code, symbol, last, input ready);
    modport sink   (input valid, char_code, symbol, last, output ready);
endinterface

[rtl/geohash_encoder.sv]
// ----------------------------------------------------------------------------
// geohash encoder
// coordinate pair in, geohash characters out, one beat per character
// ----------------------------------------------------------------------------
// A coordinate beat is clamped to the valid range, registered as a load token
// and then circulates as a single token through a row of five bisection
// cells, one bisection per cell per cycle while the output is not stalled, so
// a character takes char_bits bisections (4 for hex, 5 otherwise). Each
// character passes from the last active cell into the output register, and
// the token is fed back to the first cell for the next one. Only that one
// token goes round the row, so a new coordinate beat is not taken until the
// current item is done. Precision saturates at 16, and at 12 with the base32
// alphabet; precision zero gives no character and leaves the input ready. The
// input is ready again once the final character sits in the output register.
// Configuration writes are expected only while the block is idle.
`include "geohash_encoder_assert.svh"

module geohash_encoder
    import ghe_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [1:0]   i_cfg_idx,
    input  logic [4:0]   i_cfg_data,
    ghe_coord_if.sink    i_coord,
    ghe_char_if.source   o_char
);

    logic [2:0] r_char_bits;
    logic [4:0] r_precision;
    logic       r_busy;
    logic [4:0] r_left;
    t_tok       r_load;
    logic       r_out_valid;
    logic [6:0] r_out_code;
    logic [4:0] r_out_sym;
    logic       r_out_last;

    logic               four;
    logic [4:0]         n_chars;
    logic               accept;
    logic signed [32:0] lat_x;
    logic signed [32:0] lat_c;
    logic signed [32:0] lat_u;
    logic signed [33:0] lon_x;
    logic signed [33:0] lon_c;
    logic signed [33:0] lon_u;
    t_tok               cell_in  [CELLS];
    t_tok               cell_out [CELLS];
    logic [CELLS-1:0]   cell_valid;
    t_tok               tail;
    t_tok               fb;
    logic               out_free;
    logic               stall;
    logic               fire;
    logic               last_char;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_char_bits <= 3'd5;
            r_precision <= 5'd12;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_CHAR_BITS: r_char_bits <= i_cfg_data[2:0];
                CFG_PRECISION: r_precision <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign four = (r_char_bits == BITS_HEX);

    always_comb begin
        n_chars = (r_precision > MAX_CHARS) ? MAX_CHARS : r_precision;
        if (!four && n_chars > B32_MAX_CHARS) begin
            n_chars = B32_MAX_CHARS;
        end
    end

    // input clamp and offset to the low edge
    always_comb begin
        lat_x = 33'(i_coord.latitude);
        lon_x = 34'(i_coord.longitude);
        if (lat_x > LAT_LIM) begin
            lat_c = LAT_LIM;
        end else if (lat_x < -LAT_LIM) begin
            lat_c = -LAT_LIM;
        end else begin
            lat_c = lat_x;
        end
        if (lon_x > LON_LIM) begin
            lon_c = LON_LIM;
        end else if (lon_x < -LON_LIM) begin
            lon_c = -LON_LIM;
        end else begin
            lon_c = lon_x;
        end
        lat_u = lat_c + LAT_LIM;
        lon_u = lon_c + LON_LIM;
    end

    assign i_coord.ready = !r_busy;
    assign accept        = i_coord.valid && !r_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load.valid <= 1'b0;
        end else begin
            r_load.valid <= accept && (n_chars != 5'd0);
        end
        if (accept) begin
            r_load.on_lon  <= 1'b1;
            r_load.grp     <= 5'd0;
            r_load.lat_res <= lat_u[31:0];
            r_load.lon_res <= lon_u[32:0];
        end
    end

    // token row
    assign tail      = four ? cell_out[3] : cell_out[4];
    assign out_free  = !r_out_valid || o_char.ready;
    assign stall     = tail.valid && !out_free;
    assign fire      = tail.valid && out_free;
    assign last_char = (r_left == 5'd1);

    always_comb begin
        fb       = tail;
        fb.grp   = 5'd0;
        fb.valid = fire && !last_char;
    end

    genvar k;
    generate
        for (k = 0; k < CELLS; k++) begin : g_cell
            if (k == 0) begin : g_head
                assign cell_in[k] = fb.valid ? fb : r_load;
            end else if (k == CELLS - 1) begin : g_end
                always_comb begin
                    cell_in[k]       = cell_out[k-1];
                    cell_in[k].valid = cell_out[k-1].valid && !four;
                end
            end else begin : g_mid
                assign cell_in[k] = cell_out[k-1];
            end

            ghe_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_adv   (!stall),
                .i_tok   (cell_in[k]),
                .o_tok   (cell_out[k])
            );

            assign cell_valid[k] = cell_out[k].valid;
        end
    endgenerate

    // item bookkeeping
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_left <= 5'd0;
        end else if (accept && n_chars != 5'd0) begin
            r_busy <= 1'b1;
            r_left <= n_chars;
        end else if (fire) begin
            r_left <= r_left - 5'd1;
            if (last_char) begin
                r_busy <= 1'b0;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (o_char.ready) begin
            r_out_valid <= 1'b0;
        end
        if (fire) begin
            r_out_code <= ALPHA32[tail.grp];
            r_out_sym  <= tail.grp;
            r_out_last <= last_char;
        end
    end

    assign o_char.valid     = r_out_valid;
    assign o_char.char_code = r_out_code;
    assign o_char.symbol    = r_out_sym;
    assign o_char.last      = r_out_last;

    `GHE_ASSERT(a_one_token, $countones({r_load.valid, cell_valid}) <= 1, "extra token in row")
    `GHE_ASSERT(a_last_idle, fire && last_char |=> !r_busy, "busy after final character")
    `GHE_ASSERT(a_busy_left, r_busy |-> r_left != 5'd0, "busy with no characters left")
    `GHE_ASSERT_ALWAYS(a_load_busy, r_load.valid |-> r_busy, "load token while idle")

endmodule

[rtl/ghe_cell.sv]
// ----------------------------------------------------------------------------
// geohash bisection cell
// one bisection step on the current axis, registered toward the next cell
// ----------------------------------------------------------------------------
module ghe_cell
    import ghe_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_adv,
    input  t_tok i_tok,
    output t_tok o_tok
);

    t_tok        r_tok;
    t_tok        n_tok;
    logic        dir;
    logic [31:0] lat_sub;
    logic [32:0] lon_sub;

    always_comb begin
        n_tok   = i_tok;
        lat_sub = i_tok.lat_res;
        lon_sub = i_tok.lon_res;
        if (i_tok.on_lon) begin
            dir = (i_tok.lon_res > LON_HALF);
            if (dir) begin
                lon_sub = i_tok.lon_res - LON_HALF;
            end
            n_tok.lon_res = {lon_sub[31:0], 1'b0};
        end else begin
            dir = (i_tok.lat_res > LAT_HALF);
            if (dir) begin
                lat_sub = i_tok.lat_res - LAT_HALF;
            end
            n_tok.lat_res = {lat_sub[30:0], 1'b0};
        end
        n_tok.grp    = {i_tok.grp[3:0], dir};
        n_tok.on_lon = ~i_tok.on_lon;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.valid <= 1'b0;
        end else if (i_adv) begin
            r_tok <= n_tok;
        end
    end

    assign o_tok = r_tok;

endmodule

[dv/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// geohash encoder testbench
// drives coordinate beats with bursts and gaps, stalls the character channel,
// predicts every character from its own bisection model and checks each beat
// ----------------------------------------------------------------------------
module tb
    import ghe_pkg::*;
();

    localparam logic [1:0] CFG_SPARE_A = 2'd2;
    localparam logic [1:0] CFG_SPARE_B = 2'd3;

    localparam logic [2:0] HEX_BITS      = 3'd4;
    localparam int         MAX_GEO_CHARS = 16;
    localparam int         B32_GEO_CHARS = 12;
    localparam longint     LAT_LIMIT     = 64'sd1509949440;
    localparam longint     LON_LIMIT     = 64'sd3019898880;
    localparam logic [63:0] GEO_SPAN     = 64'd180 << 56;
    localparam logic [8*32-1:0] GEO_ALPHABET = "0123456789bcdefghjkmnpqrstuvwxyz";

    localparam int SETTLE_CYCLES = 100;
    localparam int REPORT_LIMIT  = 10;

    typedef struct packed {
        logic [6:0] code;
        logic [4:0] sym;
        logic       last;
    } t_char_beat;

    typedef enum logic [1:0] {RX_OPEN, RX_RANDOM, RX_HEAVY, RX_PATTERN} t_rx_mode;

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_cfg_we;
    logic [1:0] i_cfg_idx;
    logic [4:0] i_cfg_data;

    ghe_coord_if coord_bus ();
    ghe_char_if  char_bus ();

    geohash_encoder u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_coord    (coord_bus),
        .o_char     (char_bus)
    );

    // shadow of the block's registers
    logic [2:0] cfg_char_bits;
    logic [4:0] cfg_precision;

    t_char_beat pending_chars [$];
    t_char_beat want;
    int         fault_count = 0;

    int         burst_left = 0;
    bit         gaps_on = 1'b1;
    t_rx_mode   rx_mode = RX_OPEN;
    int         hold_request = 0;
    int         hold_left = 0;
    logic [7:0] stall_mask = 8'b1011_0010;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // bisection per axis, longitude first, alternating across characters
    function automatic void encode_geohash(input logic signed [31:0] lat,
                                           input logic signed [32:0] lon);
        logic [63:0] lat_pt, lon_pt, lat_lo, lat_hi, lon_lo, lon_hi, mid;
        longint      la, lo;
        int          width, n, pos, done;
        logic        on_lon, b;
        logic [4:0]  grp;
        t_char_beat  beat;
        width = (cfg_char_bits == HEX_BITS) ? 4 : 5;
        n = int'(cfg_precision);
        if (n > MAX_GEO_CHARS) n = MAX_GEO_CHARS;
        if (width == 5 && n > B32_GEO_CHARS) n = B32_GEO_CHARS;
        la = longint'(lat);
        lo = longint'(lon);
        if (la > LAT_LIMIT) la = LAT_LIMIT;
        if (la < -LAT_LIMIT) la = -LAT_LIMIT;
        if (lo > LON_LIMIT) lo = LON_LIMIT;
        if (lo < -LON_LIMIT) lo = -LON_LIMIT;
        // both axes scaled onto the same span so every midpoint is exact
        lat_pt = la + LAT_LIMIT;
        lat_pt = lat_pt << 32;
        lon_pt = lo + LON_LIMIT;
        lon_pt = lon_pt << 31;
        lat_lo = '0;
        lat_hi = GEO_SPAN;
        lon_lo = '0;
        lon_hi = GEO_SPAN;
        grp = '0;
        pos = 0;
        done = 0;
        on_lon = 1'b1;
        while (done < n) begin
            if (on_lon) begin
                mid = lon_lo + ((lon_hi - lon_lo) >> 1);
                b = (lon_pt > mid);
                if (b) lon_lo = mid;
                else lon_hi = mid;
            end else begin
                mid = lat_lo + ((lat_hi - lat_lo) >> 1);
                b = (lat_pt > mid);
                if (b) lat_lo = mid;
                else lat_hi = mid;
            end
            grp = {grp[3:0], b};
            pos++;
            on_lon = !on_lon;
            if (pos == width) begin
                done++;
                beat.sym  = grp;
                beat.code = GEO_ALPHABET[8*(31-grp) +: 7];
                beat.last = (done == n);
                pending_chars = {pending_chars, beat};
                grp = '0;
                pos = 0;
            end
        end
    endfunction

    // one axis value: in range, raw bits, grid points near midpoints, or edges
    function automatic longint pick_axis(input longint lim, input int width);
        longint v;
        int     s;
        case ($urandom_range(0, 19))
            0, 1, 2: begin
                v = {$urandom, $urandom};
                v = (v <<< (64 - width)) >>> (64 - width);
            end
            3, 4, 5, 6: begin
                s = $urandom_range(1, 24);
                v = -lim + longint'($urandom_range(0, 1 << s)) * ((2 * lim) >>> s)
                    + longint'($urandom_range(0, 2)) - 1;
            end
            7: begin
                case ($urandom_range(0, 7))
                    0: v = lim;
                    1: v = -lim;
                    2: v = 0;
                    3: v = lim + 1;
                    4: v = -lim - 1;
                    5: v = -1;
                    6: v = (64'sd1 <<< (width - 1)) - 1;
                    default: v = -(64'sd1 <<< (width - 1));
                endcase
            end
            default: v = longint'({$urandom, $urandom} % (2 * lim + 1)) - lim;
        endcase
        return v;
    endfunction

    // values are cut to the port widths, so raw bit patterns pass through
    task automatic send_coord(input longint lat, input longint lon);
        int                 gap;
        logic signed [31:0] lat_w;
        logic signed [32:0] lon_w;
        lat_w = 32'(lat);
        lon_w = 33'(lon);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = gaps_on ? $urandom_range(1, 6) : 0;
            if (gap != 0) begin
                coord_bus.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        coord_bus.valid     <= 1'b1;
        coord_bus.latitude  <= lat_w;
        coord_bus.longitude <= lon_w;
        @(posedge i_clk);
        while (!coord_bus.ready) @(posedge i_clk);
        encode_geohash(lat_w, lon_w);
    endtask

    // drop valid and hold until every predicted character has come out
    task automatic wait_idle();
        coord_bus.valid <= 1'b0;
        burst_left = 0;
        while (pending_chars.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // char_bits, precision, then a write to an unused index that must be ignored
    task automatic apply_config(input logic [4:0] bits_val, input logic [4:0] prec_val);
        logic [1:0] idx_seq [3];
        logic [4:0] val_seq [3];
        int         k;
        idx_seq[0] = CFG_CHAR_BITS;
        val_seq[0] = bits_val;
        idx_seq[1] = CFG_PRECISION;
        val_seq[1] = prec_val;
        idx_seq[2] = $urandom_range(0, 1) ? CFG_SPARE_A : CFG_SPARE_B;
        val_seq[2] = 5'($urandom);
        for (k = 0; k < 3; k++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= idx_seq[k];
            i_cfg_data <= val_seq[k];
            @(posedge i_clk);
            case (idx_seq[k])
                CFG_CHAR_BITS: cfg_char_bits = val_seq[k][2:0];
                CFG_PRECISION: cfg_precision = val_seq[k];
                default: ;
            endcase
        end
        i_cfg_we <= 1'b0;
    endtask

    task automatic test_reset_defaults();
        send_coord(64'sd0, 64'sd0);
        send_coord(LAT_LIMIT, LON_LIMIT);
        send_coord(-LAT_LIMIT, -LON_LIMIT);
        send_coord(-64'sd1, -64'sd1);
        send_coord(64'sd967194336, 64'sd174605318);
    endtask

    task automatic test_coord_extremes();
        wait_idle();
        apply_config(5'd4, 5'd16);
        send_coord(64'sh7fff_ffff, 64'sh0_ffff_ffff);
        send_coord(64'sh8000_0000, 64'sh1_0000_0000);
        send_coord(LAT_LIMIT + 1, -LON_LIMIT - 1);
        send_coord(LAT_LIMIT - 1, LON_LIMIT - 1);
        // second-level midpoints on both axes
        send_coord(LAT_LIMIT / 2, LON_LIMIT / 2);
        send_coord(-LAT_LIMIT + 1, -LON_LIMIT + 1);
    endtask

    task automatic test_register_modes();
        // non-hex char_bits values fall back to base32, precision capped at 12
        wait_idle();
        apply_config(5'd0, 5'd31);
        send_coord(pick_axis(LAT_LIMIT, 32), pick_axis(LON_LIMIT, 33));
        wait_idle();
        apply_config(5'd7, 5'd13);
        send_coord(pick_axis(LAT_LIMIT, 32), pick_axis(LON_LIMIT, 33));
        // upper data bits dropped from char_bits, precision capped at 16
        wait_idle();
        apply_config(5'b11100, 5'd17);
        send_coord(pick_axis(LAT_LIMIT, 32), pick_axis(LON_LIMIT, 33));
        // zero precision gives no characters at all
        wait_idle();
        apply_config(5'd4, 5'd0);
        send_coord(pick_axis(LAT_LIMIT, 32), pick_axis(LON_LIMIT, 33));
        send_coord(pick_axis(LAT_LIMIT, 32), pick_axis(LON_LIMIT, 33));
        wait_idle();
        apply_config(5'd5, 5'd1);
        send_coord(pick_axis(LAT_LIMIT, 32), pick_axis(LON_LIMIT, 33));
        wait_idle();
        apply_config(5'd4, 5'd1);
        send_coord(pick_axis(LAT_LIMIT, 32), pick_axis(LON_LIMIT, 33));
    endtask

    // character channel held off long enough that the input side backs up
    task automatic test_output_hold();
        int k;
        wait_idle();
        apply_config(5'd5, 5'd12);
        gaps_on = 1'b0;
        rx_mode = RX_OPEN;
        hold_request = 300;
        for (k = 0; k < 6; k++) send_coord(pick_axis(LAT_LIMIT, 32), pick_axis(LON_LIMIT, 33));
        wait_idle();
    endtask

    task automatic test_random_traffic();
        int         phase, k;
        logic [4:0] bits_val, prec_val;
        for (phase = 0; phase < 11; phase++) begin
            wait_idle();
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: bits_val = 5'd4;
                5, 6, 7: bits_val = 5'd5;
                default: bits_val = 5'($urandom_range(0, 31));
            endcase
            prec_val = ($urandom_range(0, 15) == 0) ? 5'($urandom_range(0, 31))
                                                    : 5'($urandom_range(1, 16));
            if (phase == 0) begin
                bits_val = 5'd4;
                prec_val = 5'd16;
            end else if (phase == 1) begin
                bits_val = 5'd5;
                prec_val = 5'd1;
            end
            apply_config(bits_val, prec_val);
            rx_mode = t_rx_mode'($urandom_range(0, 3));
            gaps_on = 1'($urandom_range(0, 1));
            for (k = 0; k < 40; k++) begin
                send_coord(pick_axis(LAT_LIMIT, 32), pick_axis(LON_LIMIT, 33));
            end
        end
    endtask

    // receiver: long hold-off when asked, otherwise its own stall pattern
    always @(posedge i_clk) begin
        if (hold_request != 0) begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left != 0) begin
            hold_left--;
            char_bus.ready <= 1'b0;
        end else begin
            case (rx_mode)
                RX_OPEN:    char_bus.ready <= 1'b1;
                RX_RANDOM:  char_bus.ready <= ($urandom_range(0, 3) != 0);
                RX_HEAVY:   char_bus.ready <= ($urandom_range(0, 3) == 0);
                RX_PATTERN: char_bus.ready <= stall_mask[0];
                default:    char_bus.ready <= 1'b1;
            endcase
        end
        stall_mask = {stall_mask[6:0], stall_mask[7]};
    end

    // every character beat against the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && char_bus.valid && char_bus.ready) begin
            if (pending_chars.size() == 0) begin
                fault_count++;
                if (fault_count <= REPORT_LIMIT)
                    $display("unexpected char beat: code %0d symbol %0d last %0b",
                             char_bus.char_code, char_bus.symbol, char_bus.last);
            end else begin
                want = pending_chars.pop_front();
                if (char_bus.char_code !== want.code || char_bus.symbol !== want.sym ||
                    char_bus.last !== want.last) begin
                    fault_count++;
                    if (fault_count <= REPORT_LIMIT)
                        $display("char mismatch: exp %0d/%0d/%0b got %0d/%0d/%0b",
                                 want.code, want.sym, want.last,
                                 char_bus.char_code, char_bus.symbol, char_bus.last);
                end
            end
        end
    end

    initial begin
        i_rst_n             <= 1'b0;
        i_cfg_we            <= 1'b0;
        i_cfg_idx           <= CFG_CHAR_BITS;
        i_cfg_data          <= '0;
        coord_bus.valid     <= 1'b0;
        coord_bus.latitude  <= '0;
        coord_bus.longitude <= '0;
        cfg_char_bits = 3'd5;
        cfg_precision = 5'd12;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_defaults();
        test_coord_extremes();
        test_register_modes();
        test_output_hold();
        test_random_traffic();
        wait_idle();
        if (fault_count == 0 && pending_chars.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule

[files.f]
+incdir+rtl
rtl/ghe_pkg.sv
rtl/ghe_coord_if.sv
rtl/ghe_char_if.sv
rtl/ghe_cell.sv
rtl/geohash_encoder.sv
dv/tb.sv
